/* rtl/vpcm_pkg.sv */
// Shared types, constants and byte-lane helpers for the virtio common-config/MSI-X block.
// No dependencies; imported by every module of the block.
package vpcm_pkg;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_IRQ   = 2'd2;

    localparam logic [2:0] CFG_DEVICE_FEATURES = 3'd0;
    localparam logic [2:0] CFG_QUEUE_COUNT     = 3'd1;
    localparam logic [2:0] CFG_QUEUE_SIZE_DEF  = 3'd2;
    localparam logic [2:0] CFG_DEVCFG_LEN      = 3'd3;
    localparam logic [2:0] CFG_DEVCFG_WORD     = 3'd4;
    localparam logic [2:0] CFG_MSIX_CONTROL    = 3'd5;

    localparam int          COMMON_LEN   = 56;
    localparam logic [15:0] NO_VECTOR    = 16'hFFFF;
    localparam logic [16:0] PBA_OFFSET   = 17'h800;
    localparam logic [15:0] QSIZE_RESET  = 16'd256;
    localparam logic [63:0] VERSION1_BIT = 64'h1_0000_0000;

    localparam logic [15:0] OFF_DEV_FSEL  = 16'd0;
    localparam logic [15:0] OFF_DRV_FSEL  = 16'd8;
    localparam logic [15:0] OFF_DRV_FEAT  = 16'd12;
    localparam logic [15:0] OFF_CFG_VEC   = 16'd16;
    localparam logic [15:0] OFF_STATUS    = 16'd20;
    localparam logic [15:0] OFF_QSEL      = 16'd22;
    localparam logic [15:0] OFF_QSIZE     = 16'd24;
    localparam logic [15:0] OFF_QVEC      = 16'd26;
    localparam logic [15:0] OFF_QEN       = 16'd28;
    localparam logic [15:0] OFF_DESC      = 16'd32;
    localparam logic [15:0] OFF_AVAIL     = 16'd40;
    localparam logic [15:0] OFF_USED      = 16'd48;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] bar_offset;
        logic [3:0]  access_size;
        logic [63:0] write_data;
        logic [15:0] interrupt_queue;
    } req_t;

    typedef struct packed {
        logic [63:0] read_data;
        logic        msi_fire;
        logic [63:0] msi_address;
        logic [31:0] msi_payload;
        logic        notify_fire;
        logic [2:0]  notify_queue;
        logic        device_reset;
    } res_t;

    typedef struct packed {
        logic [63:0] offered_feats;
        logic [3:0]  num_queues;
        logic [15:0] queue_size_default;
        logic [8:0]  devcfg_len;
        logic [63:0] device_config_word;
        logic [15:0] mx_ctrl;
    } cfg_t;

    function automatic logic [3:0] byte_count(logic [3:0] s);
        return (s > 4'd8) ? 4'd8 : s;
    endfunction

    function automatic logic [63:0] byte_mask(logic [3:0] n);
        logic [63:0] m;
        for (int i = 0; i < 8; i++) begin
            m[i*8 +: 8] = (4'(i) < n) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

    // Bytes from start upward, n of them; a start past the word gives zero.
    function automatic logic [63:0] take_bytes(logic [63:0] word, logic [8:0] start,
                                               logic [3:0] n);
        logic [63:0] v;
        v = (start < 9'd8) ? (word >> {start[2:0], 3'b000}) : 64'd0;
        return v & byte_mask(n);
    endfunction

    // Byte-wise merge of v into dst at start; lanes at or past len stay.
    function automatic logic [63:0] put_bytes(logic [63:0] dst, logic [3:0] len,
                                              logic [3:0] start, logic [3:0] n,
                                              logic [63:0] v);
        logic [63:0] d;
        logic [4:0]  pos;
        d = dst;
        for (int i = 0; i < 8; i++) begin
            pos = {1'b0, start} + 5'(i);
            if ((4'(i) < n) && (pos < {1'b0, len})) begin
                d[pos[2:0]*8 +: 8] = v[i*8 +: 8];
            end
        end
        return d;
    endfunction

endpackage

/* rtl/virtio_pci_common_cfg_msix_unit.sv */
// Top level of the virtio modern common-config / ISR / MSI-X register block.
// Depends on vpcm_pkg, vpcm_apb_regs and vpcm_core.
//
// A request accepted by start is captured in the input register, decoded
// against the state in the next cycle, and its result is registered in the
// result register, which strobes done. Throughput: one request per cycle;
// busy stays low, since each request is a single decode and mux pass over
// flip-flop state. Results cannot be stalled: done is a one-cycle strobe.
// Reset (rst_n, async, active low) restores every register but the request
// and result data registers to their virtio and MSI-X reset value at once:
// all table vectors masked, no vector assigned, queue sizes 256.
module virtio_pci_common_cfg_msix_unit #(
    parameter int QUEUES          = 8,
    parameter int VECTORS         = 4,
    parameter int ISR_BASE        = 4096,
    parameter int DEVICE_CFG_BASE = 8192,
    parameter int NOTIFY_BASE     = 12288,
    parameter int MSIX_BASE       = 16384
) (
    input  logic                clk,
    input  logic                rst_n,
    // request channel
    input  logic                start,
    output logic                busy,
    input  vpcm_pkg::req_t      request,
    // result channel
    output logic                done,
    output vpcm_pkg::res_t      result,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [5:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);
    import vpcm_pkg::*;

    cfg_t   cfg;
    req_t   req_reg;
    logic   vld_reg;

    // never busy: one request enters every cycle
    assign busy = 1'b0;

    // input register in front of the decode stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            req_reg <= request;
    end

    vpcm_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vpcm_core #(
        .QUEUES          (QUEUES),
        .VECTORS         (VECTORS),
        .ISR_BASE        (ISR_BASE),
        .DEVICE_CFG_BASE (DEVICE_CFG_BASE),
        .NOTIFY_BASE     (NOTIFY_BASE),
        .MSIX_BASE       (MSIX_BASE)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (vld_reg),
        .req       (req_reg),
        .cfg       (cfg),
        .done      (done),
        .result    (result)
    );
endmodule

/* rtl/vpcm_apb_regs.sv */
// APB configuration registers of the virtio common-config/MSI-X block.
// Depends on vpcm_pkg (cfg_t, register indexes).
module vpcm_apb_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [5:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready,
    output vpcm_pkg::cfg_t      cfg
);
    import vpcm_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[5:3];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offered_feats      <= VERSION1_BIT;
            cfg_reg.num_queues         <= 4'd1;
            cfg_reg.queue_size_default <= QSIZE_RESET;
            cfg_reg.devcfg_len         <= 9'd8;
            cfg_reg.device_config_word <= 64'd0;
            cfg_reg.mx_ctrl            <= 16'd0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                CFG_DEVICE_FEATURES: cfg_reg.offered_feats      <= pwdata;
                CFG_QUEUE_COUNT:     cfg_reg.num_queues         <= pwdata[3:0];
                CFG_QUEUE_SIZE_DEF:  cfg_reg.queue_size_default <= pwdata[15:0];
                CFG_DEVCFG_LEN:      cfg_reg.devcfg_len         <= pwdata[8:0];
                CFG_DEVCFG_WORD:     cfg_reg.device_config_word <= pwdata;
                CFG_MSIX_CONTROL:    cfg_reg.mx_ctrl            <= pwdata[15:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            CFG_DEVICE_FEATURES: prdata = cfg_reg.offered_feats;
            CFG_QUEUE_COUNT:     prdata = {60'd0, cfg_reg.num_queues};
            CFG_QUEUE_SIZE_DEF:  prdata = {48'd0, cfg_reg.queue_size_default};
            CFG_DEVCFG_LEN:      prdata = {55'd0, cfg_reg.devcfg_len};
            CFG_DEVCFG_WORD:     prdata = cfg_reg.device_config_word;
            CFG_MSIX_CONTROL:    prdata = {48'd0, cfg_reg.mx_ctrl};
            default:             prdata = 64'd0;
        endcase
    end
endmodule

/* rtl/vpcm_core.sv */
// BAR decode, common-config/queue/MSI-X state and result register.
// Depends on vpcm_pkg (req_t, res_t, cfg_t, offsets, byte helpers).
module vpcm_core #(
    parameter int QUEUES          = 8,
    parameter int VECTORS         = 4,
    parameter int ISR_BASE        = 4096,
    parameter int DEVICE_CFG_BASE = 8192,
    parameter int NOTIFY_BASE     = 12288,
    parameter int MSIX_BASE       = 16384
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  vpcm_pkg::req_t      req,
    input  vpcm_pkg::cfg_t      cfg,
    output logic                done,
    output vpcm_pkg::res_t      result
);
    import vpcm_pkg::*;

    localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int VW = (VECTORS > 1) ? $clog2(VECTORS) : 1;
    localparam logic [16:0] ISR_B   = 17'(ISR_BASE);
    localparam logic [16:0] DCB     = 17'(DEVICE_CFG_BASE);
    localparam logic [16:0] NTB     = 17'(NOTIFY_BASE);
    localparam logic [16:0] MXB     = 17'(MSIX_BASE);
    localparam logic [16:0] TAB_END = 17'(MSIX_BASE + VECTORS * 16);
    localparam logic [16:0] PBA     = 17'(MSIX_BASE) + PBA_OFFSET;

    logic [31:0]         dev_fsel_reg;
    logic [31:0]         drv_fsel_reg;
    logic [63:0]         drv_feat_reg;
    logic [15:0]         cfg_vec_reg;
    logic [7:0]          status_reg;
    logic [15:0]         qsel_reg;
    logic [7:0]          isr_reg;
    logic [15:0]         qsize_reg  [QUEUES];
    logic [15:0]         qvec_reg   [QUEUES];
    logic [QUEUES-1:0]   qen_reg;
    logic [63:0]         ring_reg   [3][QUEUES];
    logic [31:0]         tab_reg    [VECTORS][4];
    logic [VECTORS-1:0]  pend_reg;
    logic                done_reg;
    res_t                res_reg;
    res_t                res_next;

    logic [16:0]  off;
    logic [3:0]   n;
    logic [63:0]  val;
    logic [4:0]   live;
    logic         qv;
    logic [QW-1:0] qi;
    logic         is_rd, is_wr, is_irq;
    logic         r_com, r_isr, r_dev, r_tab, r_pba;
    logic         in_tab, in_ntf, in_dev;
    logic         w_tab, w_ntf, w_com;
    logic [16:0]  rel;
    logic [1:0]   wsel;
    logic [VW-1:0] vsel;
    logic [15:0]  ivec;
    logic         ivec_ok;
    logic [31:0]  tab_new;
    logic [31:0]  w0, w1, w2, w3;
    logic         msix_off;
    logic         mask_pre, now_masked;
    logic         replay, irq_send, irq_pend;
    logic         st_reset;
    logic [1:0]   rk;
    logic [63:0]  ring_new;
    logic [63:0]  feats;
    logic [COMMON_LEN*8-1:0] img;
    logic [COMMON_LEN*8-1:0] img_sh;

    assign off  = {1'b0, req.bar_offset};
    assign n    = byte_count(req.access_size);
    assign val  = req.write_data;
    assign live = ({1'b0, cfg.num_queues} < 5'(QUEUES)) ? {1'b0, cfg.num_queues}
                                                        : 5'(QUEUES);
    assign qv   = qsel_reg < {11'd0, live};
    assign qi   = qsel_reg[QW-1:0];

    assign is_rd  = req_valid && (req.operation == OP_READ);
    assign is_wr  = req_valid && (req.operation == OP_WRITE);
    assign is_irq = req_valid && (req.operation == OP_IRQ);

    assign in_tab = (off >= MXB) && (off < TAB_END);
    assign in_dev = (off >= DCB) && (off < DCB + {8'd0, cfg.devcfg_len});
    assign in_ntf = (off >= NTB) && (off < NTB + {12'd0, cfg.num_queues, 1'b0});

    // read decode priority: common, ISR, device config, table, PBA
    assign r_com = off < 17'(COMMON_LEN);
    assign r_isr = !r_com && (off == ISR_B);
    assign r_dev = !r_com && !r_isr && in_dev;
    assign r_tab = !r_com && !r_isr && !r_dev && in_tab;
    assign r_pba = !r_com && !r_isr && !r_dev && !r_tab && (off >= PBA) && (off < PBA + 17'd8);

    // write decode priority: table, notify, device config (dropped), common
    assign w_tab = is_wr && in_tab;
    assign w_ntf = is_wr && !in_tab && in_ntf;
    assign w_com = is_wr && !in_tab && !in_ntf && !in_dev && r_com;

    assign rel  = off - MXB;
    assign wsel = rel[3:2];

    // queue interrupt vector lookup
    assign ivec    = ({12'd0, req.interrupt_queue[15:0]} < {23'd0, live} ? 1'b1 : 1'b0)
                     ? qvec_reg[req.interrupt_queue[QW-1:0]] : NO_VECTOR;
    assign ivec_ok = (ivec != NO_VECTOR) && ({16'd0, ivec} < 32'(VECTORS));
    assign vsel    = is_irq ? ivec[VW-1:0] : rel[4 +: VW];

    assign msix_off = !cfg.mx_ctrl[15] || cfg.mx_ctrl[14];

    always_comb
    begin
        tab_new = 32'(put_bytes({32'd0, tab_reg[vsel][wsel]}, 4'd4, {2'd0, rel[1:0]}, n,
                                val));
        w0 = tab_reg[vsel][0];
        w1 = tab_reg[vsel][1];
        w2 = tab_reg[vsel][2];
        w3 = tab_reg[vsel][3];
        mask_pre = msix_off || w3[0];
        if (w_tab)
        begin
            case (wsel)
                2'd0:    w0 = tab_new;
                2'd1:    w1 = tab_new;
                2'd2:    w2 = tab_new;
                default: w3 = tab_new;
            endcase
        end
        now_masked = msix_off || w3[0];
    end

    assign replay   = w_tab && mask_pre && !now_masked && pend_reg[vsel];
    assign irq_send = is_irq && ivec_ok && !mask_pre;
    assign irq_pend = is_irq && ivec_ok && mask_pre;
    assign st_reset = w_com && (req.bar_offset == OFF_STATUS) && (val[7:0] == 8'd0);

    // ring slot written by a common write at 32..55
    always_comb
    begin
        if (req.bar_offset < OFF_AVAIL)
        begin
            rk = 2'd0;
            ring_new = put_bytes(ring_reg[0][qi], 4'd8, 4'(req.bar_offset - OFF_DESC), n, val);
        end
        else if (req.bar_offset < OFF_USED)
        begin
            rk = 2'd1;
            ring_new = put_bytes(ring_reg[1][qi], 4'd8, 4'(req.bar_offset - OFF_AVAIL), n, val);
        end
        else
        begin
            rk = 2'd2;
            ring_new = put_bytes(ring_reg[2][qi], 4'd8, 4'(req.bar_offset - OFF_USED), n, val);
        end
    end

    // 56-byte common image, little endian
    assign feats = cfg.offered_feats | VERSION1_BIT;
    always_comb
    begin
        img = '0;
        img[0 +: 32]   = dev_fsel_reg;
        img[32 +: 32]  = (dev_fsel_reg == 32'd0) ? feats[31:0] : feats[63:32];
        img[64 +: 32]  = drv_fsel_reg;
        img[96 +: 32]  = (drv_fsel_reg == 32'd0) ? drv_feat_reg[31:0] : drv_feat_reg[63:32];
        img[128 +: 16] = cfg_vec_reg;
        img[144 +: 16] = {12'd0, cfg.num_queues};
        img[160 +: 8]  = status_reg;
        img[176 +: 16] = qsel_reg;
        img[192 +: 16] = qv ? qsize_reg[qi] : 16'd0;
        img[208 +: 16] = qv ? qvec_reg[qi] : NO_VECTOR;
        img[224 +: 16] = {15'd0, qv && qen_reg[qi]};
        img[240 +: 16] = qv ? qsel_reg : 16'd0;
        if (qv)
        begin
            img[256 +: 64] = ring_reg[0][qi];
            img[320 +: 64] = ring_reg[1][qi];
            img[384 +: 64] = ring_reg[2][qi];
        end
    end
    assign img_sh = img >> {off[5:0], 3'b000};

    always_comb
    begin
        res_next = '0;
        if (is_rd)
        begin
            if (r_com)
                res_next.read_data = img_sh[63:0] & byte_mask(n);
            else if (r_isr)
                res_next.read_data = {56'd0, isr_reg};
            else if (r_dev)
                res_next.read_data = take_bytes(cfg.device_config_word, 9'(off - DCB), n);
            else if (r_tab)
                res_next.read_data = take_bytes({32'd0, tab_reg[vsel][wsel]},
                                                {7'd0, rel[1:0]}, n);
            else if (r_pba)
                res_next.read_data = take_bytes({32'd0, 32'(pend_reg)}, 9'(off - PBA), n);
        end
        if (replay || irq_send)
        begin
            res_next.msi_fire    = 1'b1;
            res_next.msi_address = {w1, w0};
            res_next.msi_payload = w2;
        end
        if (w_ntf)
        begin
            res_next.notify_fire  = 1'b1;
            res_next.notify_queue = 3'((off - NTB) >> 1);
        end
        res_next.device_reset = st_reset;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_fsel_reg <= 32'd0;
            drv_fsel_reg <= 32'd0;
            drv_feat_reg <= 64'd0;
            cfg_vec_reg  <= NO_VECTOR;
            status_reg   <= 8'd0;
            qsel_reg     <= 16'd0;
            isr_reg      <= 8'd0;
            qen_reg      <= '0;
            pend_reg     <= '0;
            done_reg     <= 1'b0;
            for (int i = 0; i < QUEUES; i++)
            begin
                qsize_reg[i]   <= QSIZE_RESET;
                qvec_reg[i]    <= NO_VECTOR;
                ring_reg[0][i] <= 64'd0;
                ring_reg[1][i] <= 64'd0;
                ring_reg[2][i] <= 64'd0;
            end
            for (int v = 0; v < VECTORS; v++)
            begin
                tab_reg[v][0] <= 32'd0;
                tab_reg[v][1] <= 32'd0;
                tab_reg[v][2] <= 32'd0;
                tab_reg[v][3] <= 32'd1;
            end
        end
        else
        begin
            done_reg <= req_valid;
            if (is_rd && r_isr)
                isr_reg <= 8'd0;
            if (is_irq)
                isr_reg <= isr_reg | 8'd1;
            if (irq_pend)
                pend_reg[vsel] <= 1'b1;
            if (replay)
                pend_reg[vsel] <= 1'b0;
            if (w_tab)
                tab_reg[vsel][wsel] <= tab_new;
            if (w_com)
            begin
                case (req.bar_offset)
                    OFF_DEV_FSEL: dev_fsel_reg <= val[31:0];
                    OFF_DRV_FSEL: drv_fsel_reg <= val[31:0];
                    OFF_DRV_FEAT:
                    begin
                        if (drv_fsel_reg == 32'd0)
                            drv_feat_reg[31:0] <= val[31:0];
                        else if (drv_fsel_reg == 32'd1)
                            drv_feat_reg[63:32] <= val[31:0];
                    end
                    OFF_CFG_VEC:  cfg_vec_reg <= val[15:0];
                    OFF_STATUS:
                    begin
                        if (val[7:0] != 8'd0)
                            status_reg <= val[7:0];
                    end
                    OFF_QSEL:     qsel_reg <= val[15:0];
                    OFF_QSIZE:    if (qv) qsize_reg[qi] <= val[15:0];
                    OFF_QVEC:     if (qv) qvec_reg[qi] <= val[15:0];
                    OFF_QEN:      if (qv) qen_reg[qi] <= (val[15:0] != 16'd0);
                    default:
                    begin
                        if (qv && (req.bar_offset >= OFF_DESC))
                            ring_reg[rk][qi] <= ring_new;
                    end
                endcase
            end
            // driver wrote status zero: virtio reset of the common registers and the live queues
            if (st_reset)
            begin
                dev_fsel_reg <= 32'd0;
                drv_fsel_reg <= 32'd0;
                drv_feat_reg <= 64'd0;
                cfg_vec_reg  <= NO_VECTOR;
                status_reg   <= 8'd0;
                qsel_reg     <= 16'd0;
                isr_reg      <= 8'd0;
                for (int i = 0; i < QUEUES; i++)
                begin
                    if (5'(i) < live)
                    begin
                        ring_reg[0][i] <= 64'd0;
                        ring_reg[1][i] <= 64'd0;
                        ring_reg[2][i] <= 64'd0;
                        qen_reg[i]     <= 1'b0;
                        qvec_reg[i]    <= NO_VECTOR;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;
endmodule

/* bench/virtio_pci_common_cfg_msix_unit_tb.sv */
// Self-checking bench for the virtio common-config / ISR / MSI-X register block.
// Depends on vpcm_pkg and virtio_pci_common_cfg_msix_unit; predicts every result in-bench.
// Directed tests first, then random phases under several configurations.
module virtio_pci_common_cfg_msix_unit_tb;
    import vpcm_pkg::*;

    // Block geometry, matching the instance defaults
    localparam int QUEUES          = 8;
    localparam int VECTORS         = 4;
    localparam int ISR_BASE        = 4096;
    localparam int DEVICE_CFG_BASE = 8192;
    localparam int NOTIFY_BASE     = 12288;
    localparam int MSIX_BASE       = 16384;
    localparam int PBA_BASE        = MSIX_BASE + 2048;
    localparam int TABLE_END       = MSIX_BASE + VECTORS * 16;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int LATENCY         = 3;
    localparam int STALL_LIMIT     = 5000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    req_t        request = '0;
    logic        done;
    res_t        result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    virtio_pci_common_cfg_msix_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Shadow copy of the block: configuration and register state
    // ---------------------------------------------------------------
    logic [63:0] sh_features;
    logic [3:0]  sh_qcount;
    logic [15:0] sh_qsize_def;
    logic [8:0]  sh_dcfg_len;
    logic [63:0] sh_dcfg_word;
    logic [15:0] sh_msix_ctl;

    logic [31:0] sh_dev_fsel;
    logic [31:0] sh_drv_fsel;
    logic [63:0] sh_drv_feat;
    logic [15:0] sh_cfg_vec;
    logic [7:0]  sh_status;
    logic [15:0] sh_qsel;
    logic [7:0]  sh_isr;
    logic [15:0] sh_qsize [QUEUES];
    logic [15:0] sh_qvec  [QUEUES];
    logic        sh_qen   [QUEUES];
    logic [63:0] sh_ring  [3*QUEUES];
    logic [31:0] sh_table [4*VECTORS];
    logic [31:0] sh_pending;

    res_t expected_results [$];
    int   mismatches = 0;
    int   results_seen = 0;
    int   requests_sent = 0;
    int   msi_seen = 0;
    int   notify_seen = 0;
    int   resets_seen = 0;
    bit   burst_mode = 1'b0;

    function automatic void shadow_reset();
        sh_features  = VERSION1_BIT;
        sh_qcount    = 4'd1;
        sh_qsize_def = QSIZE_RESET;
        sh_dcfg_len  = 9'd8;
        sh_dcfg_word = '0;
        sh_msix_ctl  = '0;
        sh_dev_fsel  = '0;
        sh_drv_fsel  = '0;
        sh_drv_feat  = '0;
        sh_cfg_vec   = NO_VECTOR;
        sh_status    = '0;
        sh_qsel      = '0;
        sh_isr       = '0;
        for (int i = 0; i < QUEUES; i++)
        begin
            sh_qsize[i] = QSIZE_RESET;
            sh_qvec[i]  = NO_VECTOR;
            sh_qen[i]   = 1'b0;
        end
        for (int i = 0; i < 3*QUEUES; i++) sh_ring[i] = '0;
        for (int i = 0; i < 4*VECTORS; i++) sh_table[i] = ((i % 4) == 3) ? 32'd1 : 32'd0;
        sh_pending = '0;
    endfunction

    function automatic int live_queues();
        return (sh_qcount < QUEUES) ? int'(sh_qcount) : QUEUES;
    endfunction

    function automatic logic [63:0] pick_bytes(logic [63:0] word, int first, int n);
        logic [63:0] v;
        v = (first < 8) ? (word >> (first * 8)) : 64'd0;
        if (n < 8) v &= (64'd1 << (n * 8)) - 64'd1;
        return v;
    endfunction

    function automatic logic [63:0] merge_bytes(logic [63:0] dst, int len, int first, int n,
                                                logic [63:0] v);
        logic [63:0] d;
        d = dst;
        for (int i = 0; i < n; i++)
        begin
            if (first + i >= len) break;
            d[(first + i) * 8 +: 8] = v[i * 8 +: 8];
        end
        return d;
    endfunction

    function automatic bit vector_masked(int v);
        if (v >= VECTORS) return 1'b1;
        if (!sh_msix_ctl[15] || sh_msix_ctl[14]) return 1'b1;
        return sh_table[v * 4 + 3][0];
    endfunction

    function automatic void load_msi(int v, inout res_t r);
        r.msi_fire    = 1'b1;
        r.msi_address = {sh_table[v * 4 + 1], sh_table[v * 4]};
        r.msi_payload = sh_table[v * 4 + 2];
    endfunction

    function automatic logic [63:0] common_image_read(int off, int n);
        logic [447:0] img;
        logic [63:0]  feats;
        logic [63:0]  w;
        int           q;
        bit           qv;
        q     = sh_qsel;
        qv    = q < live_queues();
        feats = sh_features | VERSION1_BIT;
        img   = '0;
        w     = '0;
        img[31:0]    = sh_dev_fsel;
        img[63:32]   = (sh_dev_fsel == 0) ? feats[31:0] : feats[63:32];
        img[95:64]   = sh_drv_fsel;
        img[127:96]  = (sh_drv_fsel == 0) ? sh_drv_feat[31:0] : sh_drv_feat[63:32];
        img[143:128] = sh_cfg_vec;
        img[159:144] = {12'd0, sh_qcount};
        img[167:160] = sh_status;
        img[191:176] = sh_qsel;
        if (qv)
        begin
            img[207:192] = sh_qsize[q];
            img[223:208] = sh_qvec[q];
            img[239:224] = {15'd0, sh_qen[q]};
            img[255:240] = 16'(q);
            img[319:256] = sh_ring[q * 3];
            img[383:320] = sh_ring[q * 3 + 1];
            img[447:384] = sh_ring[q * 3 + 2];
        end
        else
        begin
            img[223:208] = NO_VECTOR;
        end
        for (int i = 0; i < n; i++)
            if (off + i < COMMON_LEN) w[i * 8 +: 8] = img[(off + i) * 8 +: 8];
        return w;
    endfunction

    function automatic void driver_reset();
        sh_drv_feat = '0;
        sh_dev_fsel = '0;
        sh_drv_fsel = '0;
        sh_cfg_vec  = NO_VECTOR;
        sh_qsel     = '0;
        sh_status   = '0;
        sh_isr      = '0;
        for (int i = 0; i < live_queues(); i++)
        begin
            sh_ring[i * 3]     = '0;
            sh_ring[i * 3 + 1] = '0;
            sh_ring[i * 3 + 2] = '0;
            sh_qen[i]  = 1'b0;
            sh_qvec[i] = NO_VECTOR;
        end
    endfunction

    // Expected outcome of one BAR request; updates the shadow state.
    function automatic res_t bar_access_outcome(req_t rq);
        res_t        r;
        int          off, n, q, v, e, idx, k, iq;
        bit          qv, was;
        logic [63:0] val;
        r   = '0;
        off = rq.bar_offset;
        n   = (rq.access_size > 8) ? 8 : int'(rq.access_size);
        val = rq.write_data;
        iq  = rq.interrupt_queue;
        q   = sh_qsel;
        qv  = q < live_queues();
        case (rq.operation)
            OP_READ:
            begin
                if (off < COMMON_LEN)
                    r.read_data = common_image_read(off, n);
                else if (off == ISR_BASE)
                begin
                    r.read_data = {56'd0, sh_isr};
                    sh_isr = '0;
                end
                else if (off >= DEVICE_CFG_BASE && off < DEVICE_CFG_BASE + sh_dcfg_len)
                    r.read_data = pick_bytes(sh_dcfg_word, off - DEVICE_CFG_BASE, n);
                else if (off >= MSIX_BASE && off < TABLE_END)
                begin
                    v = (off - MSIX_BASE) / 16;
                    e = (off - MSIX_BASE) % 16;
                    r.read_data = pick_bytes({32'd0, sh_table[v * 4 + e / 4]}, e % 4, n);
                end
                else if (off >= PBA_BASE && off < PBA_BASE + 8)
                    r.read_data = pick_bytes({32'd0, sh_pending}, off - PBA_BASE, n);
            end
            OP_WRITE:
            begin
                if (off >= MSIX_BASE && off < TABLE_END)
                begin
                    v   = (off - MSIX_BASE) / 16;
                    e   = (off - MSIX_BASE) % 16;
                    idx = v * 4 + e / 4;
                    was = vector_masked(v);
                    sh_table[idx] = 32'(merge_bytes({32'd0, sh_table[idx]}, 4, e % 4, n, val));
                    if (was && !vector_masked(v) && sh_pending[v])
                    begin
                        sh_pending[v] = 1'b0;
                        load_msi(v, r);
                    end
                end
                else if (off >= NOTIFY_BASE && off < NOTIFY_BASE + sh_qcount * 2)
                begin
                    r.notify_fire  = 1'b1;
                    r.notify_queue = 3'((off - NOTIFY_BASE) / 2);
                end
                else if (off >= DEVICE_CFG_BASE && off < DEVICE_CFG_BASE + sh_dcfg_len)
                begin
                    // device config window is read-only here
                end
                else if (off < COMMON_LEN)
                begin
                    case (16'(off))
                        OFF_DEV_FSEL: sh_dev_fsel = val[31:0];
                        OFF_DRV_FSEL: sh_drv_fsel = val[31:0];
                        OFF_DRV_FEAT:
                        begin
                            if (sh_drv_fsel == 0) sh_drv_feat[31:0] = val[31:0];
                            else if (sh_drv_fsel == 1) sh_drv_feat[63:32] = val[31:0];
                        end
                        OFF_CFG_VEC: sh_cfg_vec = val[15:0];
                        OFF_STATUS:
                        begin
                            if (val[7:0] == 0)
                            begin
                                driver_reset();
                                r.device_reset = 1'b1;
                            end
                            else sh_status = val[7:0];
                        end
                        OFF_QSEL:  sh_qsel = val[15:0];
                        OFF_QSIZE: if (qv) sh_qsize[q] = val[15:0];
                        OFF_QVEC:  if (qv) sh_qvec[q] = val[15:0];
                        OFF_QEN:   if (qv) sh_qen[q] = (val[15:0] != 0);
                        default:
                        begin
                            if (qv && off >= OFF_DESC)
                            begin
                                k = (off < OFF_AVAIL) ? 0 : ((off < OFF_USED) ? 1 : 2);
                                sh_ring[q * 3 + k] = merge_bytes(sh_ring[q * 3 + k], 8,
                                                                 off - (32 + 8 * k), n, val);
                            end
                        end
                    endcase
                end
            end
            OP_IRQ:
            begin
                v = NO_VECTOR;
                if (iq < live_queues()) v = sh_qvec[iq];
                sh_isr[0] = 1'b1;
                if (v != NO_VECTOR && v < VECTORS)
                begin
                    if (vector_masked(v)) sh_pending[v] = 1'b1;
                    else load_msi(v, r);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Result checking: every done strobe against the oldest expectation
    // ---------------------------------------------------------------
    task automatic report_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %0d on %s: expected %h got %h", mismatches, name, exp_v, got_v);
    endtask

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result with nothing pending");
            end
            else
            begin
                want = expected_results.pop_front();
                if (want.msi_fire) msi_seen++;
                if (want.notify_fire) notify_seen++;
                if (want.device_reset) resets_seen++;
                if (result.read_data !== want.read_data)
                    report_field("read_data", want.read_data, result.read_data);
                if (result.msi_fire !== want.msi_fire)
                    report_field("msi_fire", want.msi_fire, result.msi_fire);
                if (result.msi_address !== want.msi_address)
                    report_field("msi_address", want.msi_address, result.msi_address);
                if (result.msi_payload !== want.msi_payload)
                    report_field("msi_payload", want.msi_payload, result.msi_payload);
                if (result.notify_fire !== want.notify_fire)
                    report_field("notify_fire", want.notify_fire, result.notify_fire);
                if (result.notify_queue !== want.notify_queue)
                    report_field("notify_queue", want.notify_queue, result.notify_queue);
                if (result.device_reset !== want.device_reset)
                    report_field("device_reset", want.device_reset, result.device_reset);
            end
        end
    end

    // Watchdog: cycles with no request accepted, no result seen and no config access
    int stall_cycles = 0;
    always @(posedge clk)
    begin
        if ((start && !busy) || done || psel) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Driving helpers
    // ---------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (burst_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Send one request; start stays high back to back when no gap follows.
    task automatic send_request(req_t rq, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= rq;
        do @(posedge clk); while (busy);
        expected_results.push_back(bar_access_outcome(rq));
        requests_sent++;
    endtask

    task automatic bar_op(logic [1:0] op, int off, int size, logic [63:0] data, int irq_q = 0);
        req_t rq;
        rq.operation       = op;
        rq.bar_offset      = 16'(off);
        rq.access_size     = 4'(size);
        rq.write_data      = data;
        rq.interrupt_queue = 16'(irq_q);
        send_request(rq, pick_gap());
    endtask

    // Drain all outstanding results, then let the pipeline settle.
    task automatic wait_quiet();
        start <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [63:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            CFG_DEVICE_FEATURES: sh_features  = value;
            CFG_QUEUE_COUNT:     sh_qcount    = value[3:0];
            CFG_QUEUE_SIZE_DEF:  sh_qsize_def = value[15:0];
            CFG_DEVCFG_LEN:      sh_dcfg_len  = value[8:0];
            CFG_DEVCFG_WORD:     sh_dcfg_word = value;
            CFG_MSIX_CONTROL:    sh_msix_ctl  = value[15:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(logic [63:0] feats, int qcnt, int qdef, int dlen,
                                logic [63:0] dword, int mctl);
        wait_quiet();
        cfg_write(CFG_DEVICE_FEATURES, feats);
        cfg_write(CFG_QUEUE_COUNT, 64'(qcnt));
        cfg_write(CFG_QUEUE_SIZE_DEF, 64'(qdef));
        cfg_write(CFG_DEVCFG_LEN, 64'(dlen));
        cfg_write(CFG_DEVCFG_WORD, dword);
        cfg_write(CFG_MSIX_CONTROL, 64'(mctl));
        @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Directed tests
    // ---------------------------------------------------------------
    task automatic test_reset_image();
        for (int off = 0; off < 56; off += 8) bar_op(OP_READ, off, 8, '0);
        bar_op(OP_READ, ISR_BASE, 1, '0);
        bar_op(OP_READ, PBA_BASE, 8, '0);
    endtask

    task automatic test_features_and_status();
        bar_op(OP_WRITE, OFF_DEV_FSEL, 4, 64'd1);
        bar_op(OP_READ, 4, 4, '0);
        bar_op(OP_WRITE, OFF_DRV_FSEL, 4, 64'd1);
        bar_op(OP_WRITE, OFF_DRV_FEAT, 4, 64'hFFFF_FFFF_FFFF_FFFF);
        bar_op(OP_WRITE, OFF_DRV_FSEL, 4, 64'd7);       // select with no half
        bar_op(OP_WRITE, OFF_DRV_FEAT, 4, 64'h1234_5678);
        bar_op(OP_READ, 8, 8, '0);
        bar_op(OP_WRITE, OFF_STATUS, 1, 64'h0F);
        bar_op(OP_WRITE, OFF_STATUS, 1, 64'h100);        // low byte zero: device reset
        bar_op(OP_READ, 16, 8, '0);
    endtask

    task automatic test_msix_replay();
        bar_op(OP_WRITE, OFF_QVEC, 2, 64'd0);
        bar_op(OP_IRQ, 0, 0, '0, 0);                     // masked: sets pending
        bar_op(OP_READ, PBA_BASE, 8, '0);
        bar_op(OP_WRITE, MSIX_BASE, 8, 64'hDEAD_BEEF_CAFE_F00D);
        bar_op(OP_WRITE, MSIX_BASE + 4, 4, 64'hFEE0_0000);
        bar_op(OP_WRITE, MSIX_BASE + 8, 4, 64'h4021);
        bar_op(OP_WRITE, MSIX_BASE + 12, 4, 64'd0);      // unmask: pending replays
        bar_op(OP_IRQ, 0, 0, '0, 0);
        bar_op(OP_IRQ, 0, 0, '0, 65535);                 // queue not exposed
        bar_op(OP_READ, ISR_BASE, 1, '0);
    endtask

    task automatic test_edges();
        bar_op(OP_WRITE, NOTIFY_BASE, 2, '0);
        bar_op(OP_WRITE, NOTIFY_BASE + 2, 2, '0);        // past exposed queues
        bar_op(OP_READ, 0, 0, '0);                       // zero-byte access
        bar_op(OP_READ, 50, 15, '0);                     // oversize, runs past image
        bar_op(OP_UNUSED, 16'hFFFF, 15, 64'hFFFF_FFFF_FFFF_FFFF, 65535);
        bar_op(OP_WRITE, OFF_QSEL, 2, 64'd9);            // out-of-range queue
        bar_op(OP_READ, 24, 8, '0);
        bar_op(OP_WRITE, OFF_QSIZE, 2, 64'd5);
    endtask

    // ---------------------------------------------------------------
    // Random requests, weighted toward register sequences that matter
    // ---------------------------------------------------------------
    function automatic int pick_offset();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
        begin
            case ($urandom_range(0, 10))
                0: return OFF_DEV_FSEL;
                1: return OFF_DRV_FSEL;
                2: return OFF_DRV_FEAT;
                3: return OFF_CFG_VEC;
                4: return OFF_STATUS;
                5: return OFF_QSEL;
                6: return OFF_QSIZE;
                7: return OFF_QVEC;
                8: return OFF_QEN;
                default: return $urandom_range(32, 55);
            endcase
        end
        if (r < 42) return $urandom_range(0, 63);
        if (r < 48) return ISR_BASE + (($urandom_range(0, 3) == 0) ? 1 : 0);
        if (r < 56) return DEVICE_CFG_BASE + $urandom_range(0, 263);
        if (r < 66) return NOTIFY_BASE + $urandom_range(0, 33);
        if (r < 86) return MSIX_BASE + $urandom_range(0, 71);
        if (r < 93) return PBA_BASE + $urandom_range(0, 9);
        return $urandom_range(0, 65535);
    endfunction

    function automatic req_t random_request();
        req_t rq;
        int   r;
        r = $urandom_range(0, 99);
        rq.operation  = (r < 33) ? OP_READ : (r < 73) ? OP_WRITE : (r < 96) ? OP_IRQ : OP_UNUSED;
        rq.bar_offset = 16'(pick_offset());
        case ($urandom_range(0, 9))
            0, 1:    rq.access_size = 4'd1;
            2, 3:    rq.access_size = 4'd2;
            4, 5, 6: rq.access_size = 4'd4;
            7, 8:    rq.access_size = 4'd8;
            default: rq.access_size = 4'($urandom_range(0, 15));
        endcase
        rq.write_data = {$urandom(), $urandom()};
        // Keep selects, vectors and status mostly meaningful
        if (rq.bar_offset == OFF_QSEL && $urandom_range(0, 4) != 0)
            rq.write_data = 64'($urandom_range(0, 9));
        if (rq.bar_offset == OFF_QVEC && $urandom_range(0, 4) != 0)
            rq.write_data = ($urandom_range(0, 5) == 0) ? 64'(NO_VECTOR)
                                                         : 64'($urandom_range(0, 4));
        if ((rq.bar_offset == OFF_DRV_FSEL || rq.bar_offset == OFF_DEV_FSEL)
            && $urandom_range(0, 3) != 0)
            rq.write_data = 64'($urandom_range(0, 2));
        if (rq.bar_offset == OFF_STATUS && $urandom_range(0, 5) == 0)
            rq.write_data[7:0] = 8'd0;
        if (rq.bar_offset >= MSIX_BASE && rq.bar_offset < TABLE_END
            && rq.bar_offset[3:2] == 2'd3 && $urandom_range(0, 2) != 0)
            rq.write_data = 64'($urandom_range(0, 1));
        rq.interrupt_queue = ($urandom_range(0, 7) == 0) ? 16'($urandom())
                                                          : 16'($urandom_range(0, 9));
        return rq;
    endfunction

    task automatic test_random_phase(int count);
        burst_mode = ($urandom_range(0, 2) == 0);
        // Point queues at vectors so interrupts have somewhere to go
        for (int i = 0; i < 3; i++)
        begin
            bar_op(OP_WRITE, OFF_QSEL, 2, 64'($urandom_range(0, 7)));
            bar_op(OP_WRITE, OFF_QVEC, 2, 64'($urandom_range(0, VECTORS - 1)));
        end
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 59) == 0)
            begin
                start <= 1'b0;
                @(posedge clk);
                while (expected_results.size() != 0) @(posedge clk);
            end
            if ($urandom_range(0, 49) == 0) burst_mode = !burst_mode;
            send_request(random_request(), pick_gap());
        end
        burst_mode = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial
    begin
        shadow_reset();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_image();
        test_features_and_status();
        apply_config(VERSION1_BIT, 1, 256, 8, 64'h0807_0605_0403_0201, 16'h8000);
        test_msix_replay();
        test_edges();

        apply_config(64'hFFFF_FFFF_FFFF_FFFF, 8, 32768, 256,
                     64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
        test_random_phase(80);
        apply_config(64'd0, 0, 0, 0, 64'd0, 16'h0000);
        test_random_phase(60);
        apply_config(64'hA5A5_5A5A_0F0F_F0F0, 15, 1, 256, 64'h0123_4567_89AB_CDEF, 16'h8000);
        test_random_phase(120);
        apply_config({$urandom(), $urandom()}, 8, $urandom_range(0, 32768),
                     $urandom_range(0, 256), {$urandom(), $urandom()}, 16'hC000);
        test_random_phase(60);
        apply_config({$urandom(), $urandom()}, $urandom_range(1, 8), $urandom_range(0, 32768),
                     $urandom_range(0, 256), {$urandom(), $urandom()}, 16'h8000);
        test_random_phase(180);

        wait_quiet();
        repeat (LATENCY) @(posedge clk);
        $display("covered %0d requests, %0d results: %0d MSI sends, %0d notifies, %0d resets",
                 requests_sent, results_seen, msi_seen, notify_seen, resets_seen);
        $display("%0d mismatches, %0d results still outstanding",
                 mismatches, expected_results.size());
        if (mismatches == 0 && expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* filelist.f */
rtl/vpcm_pkg.sv
rtl/vpcm_apb_regs.sv
rtl/vpcm_core.sv
rtl/virtio_pci_common_cfg_msix_unit.sv
bench/virtio_pci_common_cfg_msix_unit_tb.sv
